// ----- src/jsd_pkg.sv -----
// Shared types, constants and helper functions for the JSON string decoder.
// Used by jsd_decode, jsd_outq and json_string_decoder; no dependencies.
package jsd_pkg;

  // Decoded length counter and configuration widths
  localparam int CountWidth = 21;
  localparam int CfgWidth   = 20;
  localparam int SumWidth   = ((CountWidth > CfgWidth) ? CountWidth : CfgWidth) + 1;
  localparam int MaxResults = 4;

  // Reset value of the length limit register
  localparam logic [CfgWidth-1:0] MaxBytesReset = CfgWidth'(65535);

  // Register indexes on the configuration port
  localparam logic REG_MAX_BYTES = 1'b0;

  // Character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  // Decode phase
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_STR      = 4'd1,
    PH_ESC      = 4'd2,
    PH_HEX1     = 4'd3,
    PH_HEX1_BAD = 4'd4,
    PH_WANT_BS  = 4'd5,
    PH_WANT_U   = 4'd6,
    PH_HEX2     = 4'd7,
    PH_HEX2_BAD = 4'd8,
    PH_UTF8     = 4'd9
  } phase_e;

  // Error codes
  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_TRUNC_ESC    = 4'd1,
    ERR_TRUNC_HEX    = 4'd2,
    ERR_BAD_HEX      = 4'd3,
    ERR_NO_LOW       = 4'd4,
    ERR_BAD_LOW      = 4'd5,
    ERR_LONE_LOW     = 4'd6,
    ERR_BAD_ESC      = 4'd7,
    ERR_BAD_UTF8     = 4'd8,
    ERR_TOO_LONG     = 4'd9,
    ERR_UNTERMINATED = 4'd10
  } err_e;

  // All results caused by one input item
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [2:0]                 nb;
    logic                       done;
    err_e                       err;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [2:0]                 nb;
  } enc_t;

  // Value of one ASCII hex digit
  function automatic hex_t hex_digit(logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      h.val = b[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // UTF-8 encoding of a code point up to 0x10FFFF
  function automatic enc_t encode_cp(logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp <= 21'h7f) begin
      e.bytes[0] = cp[7:0];
      e.nb = 3'd1;
    end else if (cp <= 21'h7ff) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.nb = 3'd2;
    end else if (cp <= 21'hffff) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.nb = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.nb = 3'd4;
    end
    return e;
  endfunction

endpackage

// ----- src/jsd_decode.sv -----
// Decode state and single-pass step logic: one input item in, at most one result bundle pushed out.
// Depends on jsd_pkg.
module jsd_decode import jsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_i,
  input  logic                final_req_i,
  input  logic [CfgWidth-1:0] max_bytes_i,
  output logic                push_o,
  output bundle_t             bundle_o
);

  phase_e                phase_q, phase_d;
  logic [20:0]           acc_q, acc_d;
  logic [9:0]            hi_q, hi_d;
  logic [23:0]           held_q, held_d;
  logic [1:0]            rem_q, rem_d;
  logic [2:0]            len_q, len_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;

  logic [MaxResults-1:0][7:0] bytes;
  logic [2:0]            nb;
  err_e                  err;
  logic                  done;
  logic                  active;
  logic                  lead;
  logic                  enc_req;
  logic [20:0]           enc_cp;
  enc_t                  enc;
  hex_t                  hx;
  logic                  second;
  logic                  bad;
  logic [20:0]           acc_hex;
  logic [20:0]           acc_utf;
  logic [SumWidth-1:0]   cnt_next;

  assign hx      = hex_digit(data_byte_i);
  assign enc     = encode_cp(enc_cp);
  assign acc_utf = {acc_q[14:0], data_byte_i[5:0]};

  // Step the decoder over one byte
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    hi_d    = hi_q;
    held_d  = held_q;
    rem_d   = rem_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    bytes   = '0;
    nb      = 3'd0;
    err     = ERR_NONE;
    done    = 1'b0;
    active  = 1'b1;
    lead    = 1'b0;
    enc_req = 1'b0;
    enc_cp  = 21'd0;
    second  = (phase_q == PH_HEX2) || (phase_q == PH_HEX2_BAD);
    bad     = (phase_q == PH_HEX1_BAD) || (phase_q == PH_HEX2_BAD) || !hx.ok;
    acc_hex = hx.ok ? {5'd0, acc_q[11:0], hx.val} : acc_q;

    if (first_i) begin
      phase_d = PH_STR;
      acc_d   = 21'd0;
      hi_d    = 10'd0;
      rem_d   = 2'd0;
      len_d   = 3'd0;
      cnt_d   = '0;
    end else begin
      case (phase_q)
        PH_STR: begin
          if (data_byte_i == CH_QUOTE) begin
            done = 1'b1;
          end else if (data_byte_i == CH_BSLASH) begin
            phase_d = PH_ESC;
          end else if (data_byte_i < 8'h20) begin
            err = ERR_BAD_UTF8;
          end else if (data_byte_i <= 8'h7f) begin
            bytes[0] = data_byte_i;
            nb = 3'd1;
          end else if (data_byte_i >= 8'hc2 && data_byte_i <= 8'hdf) begin
            acc_d = {16'd0, data_byte_i[4:0]};
            len_d = 3'd2;
            lead  = 1'b1;
          end else if (data_byte_i >= 8'he0 && data_byte_i <= 8'hef) begin
            acc_d = {17'd0, data_byte_i[3:0]};
            len_d = 3'd3;
            lead  = 1'b1;
          end else if (data_byte_i >= 8'hf0 && data_byte_i <= 8'hf4) begin
            acc_d = {18'd0, data_byte_i[2:0]};
            len_d = 3'd4;
            lead  = 1'b1;
          end else begin
            err = ERR_BAD_UTF8;
          end
          // Hold the lead byte of a raw sequence
          if (lead) begin
            held_d  = {16'd0, data_byte_i};
            rem_d   = 2'(len_d - 3'd1);
            phase_d = PH_UTF8;
          end
        end
        PH_ESC: begin
          phase_d = PH_STR;
          unique case (data_byte_i)
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
              bytes[0] = data_byte_i;
              nb = 3'd1;
            end
            CH_B: begin bytes[0] = 8'h08; nb = 3'd1; end
            CH_F: begin bytes[0] = 8'h0c; nb = 3'd1; end
            CH_N: begin bytes[0] = 8'h0a; nb = 3'd1; end
            CH_R: begin bytes[0] = 8'h0d; nb = 3'd1; end
            CH_T: begin bytes[0] = 8'h09; nb = 3'd1; end
            CH_U: begin
              phase_d = PH_HEX1;
              acc_d   = 21'd0;
              rem_d   = 2'd0;
            end
            default: err = ERR_BAD_ESC;
          endcase
        end
        PH_HEX1, PH_HEX1_BAD, PH_HEX2, PH_HEX2_BAD: begin
          acc_d = acc_hex;
          if (rem_q < 2'd3) begin
            rem_d = rem_q + 2'd1;
            if (second) begin
              phase_d = bad ? PH_HEX2_BAD : PH_HEX2;
            end else begin
              phase_d = bad ? PH_HEX1_BAD : PH_HEX1;
            end
          end else if (bad) begin
            err = ERR_BAD_HEX;
          end else if (!second) begin
            if (acc_hex >= 21'hd800 && acc_hex <= 21'hdbff) begin
              hi_d    = acc_hex[9:0];
              phase_d = PH_WANT_BS;
            end else if (acc_hex >= 21'hdc00 && acc_hex <= 21'hdfff) begin
              err = ERR_LONE_LOW;
            end else begin
              enc_req = 1'b1;
              enc_cp  = acc_hex;
              phase_d = PH_STR;
            end
          end else if (acc_hex < 21'hdc00 || acc_hex > 21'hdfff) begin
            err = ERR_BAD_LOW;
          end else begin
            // Join the surrogate pair
            enc_req = 1'b1;
            enc_cp  = 21'h10000 + {1'b0, hi_q, acc_hex[9:0]};
            phase_d = PH_STR;
          end
          if (enc_req) begin
            bytes = enc.bytes;
            nb    = enc.nb;
          end
        end
        PH_WANT_BS: begin
          if (data_byte_i == CH_BSLASH) begin
            phase_d = PH_WANT_U;
          end else begin
            err = ERR_NO_LOW;
          end
        end
        PH_WANT_U: begin
          if (data_byte_i == CH_U) begin
            phase_d = PH_HEX2;
            acc_d   = 21'd0;
            rem_d   = 2'd0;
          end else begin
            err = ERR_NO_LOW;
          end
        end
        PH_UTF8: begin
          if (data_byte_i[7:6] != 2'b10) begin
            err = ERR_BAD_UTF8;
          end else begin
            acc_d = acc_utf;
            if (rem_q > 2'd1) begin
              rem_d  = rem_q - 2'd1;
              held_d = {held_q[15:0], data_byte_i};
            end else if ((len_q == 3'd3 && acc_utf < 21'h800) ||
                         (len_q == 3'd4 && acc_utf < 21'h10000) ||
                         (acc_utf >= 21'hd800 && acc_utf <= 21'hdfff) ||
                         acc_utf > 21'h10ffff || len_q < 3'd2 || len_q > 3'd4) begin
              err = ERR_BAD_UTF8;
            end else begin
              // Release the whole sequence
              if (len_q == 3'd2) begin
                bytes[0] = held_q[7:0];
                bytes[1] = data_byte_i;
              end else if (len_q == 3'd3) begin
                bytes[0] = held_q[15:8];
                bytes[1] = held_q[7:0];
                bytes[2] = data_byte_i;
              end else begin
                bytes[0] = held_q[23:16];
                bytes[1] = held_q[15:8];
                bytes[2] = held_q[7:0];
                bytes[3] = data_byte_i;
              end
              nb      = len_q;
              rem_d   = 2'd0;
              phase_d = PH_STR;
            end
          end
        end
        default: active = 1'b0;
      endcase
    end

    // Enforce the decoded length limit
    cnt_next = SumWidth'(cnt_q) + SumWidth'(nb);
    if (err == ERR_NONE && nb != 3'd0) begin
      if (cnt_next > SumWidth'(max_bytes_i) ||
          cnt_next > SumWidth'({CountWidth{1'b1}})) begin
        err   = ERR_TOO_LONG;
        nb    = 3'd0;
        bytes = '0;
      end else begin
        cnt_d = cnt_next[CountWidth-1:0];
      end
    end

    // Flag truncation on the final byte
    if (err == ERR_NONE && !done && final_req_i) begin
      unique case (phase_d)
        PH_ESC: err = ERR_TRUNC_ESC;
        PH_HEX1, PH_HEX1_BAD, PH_HEX2, PH_HEX2_BAD: err = ERR_TRUNC_HEX;
        PH_WANT_BS, PH_WANT_U: err = ERR_NO_LOW;
        PH_UTF8: err = ERR_BAD_UTF8;
        default: err = ERR_UNTERMINATED;
      endcase
    end

    if (err != ERR_NONE || done) begin
      phase_d = PH_IDLE;
    end
  end

  // Hand the bundle to the output queue
  assign push_o        = accept_i && active && (nb != 3'd0 || err != ERR_NONE || done);
  assign bundle_o.bytes = bytes;
  assign bundle_o.nb    = nb;
  assign bundle_o.done  = done;
  assign bundle_o.err   = err;

  // Advance the state on each accepted item, except items ignored in the idle phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= 21'd0;
      hi_q    <= 10'd0;
      rem_q   <= 2'd0;
      len_q   <= 3'd0;
      cnt_q   <= '0;
    end else if (accept_i && active) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      hi_q    <= hi_d;
      rem_q   <= rem_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  // Held raw bytes are payload and need no reset
  always_ff @(posedge clk_i) begin
    if (accept_i && active) begin
      held_q <= held_d;
    end
  end

endmodule

// ----- src/jsd_outq.sv -----
// Two-entry result bundle queue that emits one result item per cycle while take_i is high.
// Depends on jsd_pkg.
module jsd_outq import jsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bundle_t    bundle_i,
  output logic       ready_o,
  output logic       valid_o,
  input  logic       take_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       done_o,
  output err_e       err_o,
  output logic       last_o
);

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;
  logic [1:0] k_q;
  bundle_t    head;
  logic [2:0] n_res;
  logic       pop;

  assign head    = mem_q[rd_q];
  assign n_res   = (head.nb == 3'd0) ? 3'd1 : head.nb;
  assign ready_o = (fill_q != 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign last_o  = ({1'b0, k_q} == n_res - 3'd1);
  assign pop     = valid_o && take_i && last_o;

  // Select the current result of the head bundle
  assign out_valid_o = ({1'b0, k_q} < head.nb);
  assign out_byte_o  = out_valid_o ? head.bytes[k_q] : 8'd0;
  assign done_o      = last_o && head.done;
  assign err_o       = last_o ? head.err : ERR_NONE;

  // Store bundles
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  // Track pointers, fill level and result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
      k_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
        k_q  <= 2'd0;
      end else if (valid_o && take_i) begin
        k_q <= k_q + 2'd1;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

// ----- src/json_string_decoder.sv -----
// JSON string decoder top level: stream ports, configuration register, decoder and output queue.
// Depends on jsd_pkg, jsd_decode and jsd_outq.
//
// Feed one byte of JSON text per item, the opening quote marked with the first flag in
// s_axis_tuser and the byte after which no input follows marked with s_axis_tlast. The
// decoder takes one item per cycle while the queue has room and produces zero to four result
// items for it: the decoded UTF-8 bytes, with done or an error code on the last of them (or on
// a single result with no byte). Results leave at one per cycle while m_axis_tready is high; a
// two-bundle queue lets input run ahead by one item while an output stalls. Each bundle is
// registered in the queue before its results appear.
// max_decoded_bytes sits at byte address 0 and should be written while the block is idle.
module json_string_decoder import jsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] first
  input  logic        s_axis_tlast,   // final_req
  // Result item stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] done_res, [12:9] error_code
  output logic [0:0]  m_axis_tuser,   // [0] out_valid
  output logic        m_axis_tlast,   // last
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CfgWidth-1:0] max_bytes_q;
  logic                accept;
  logic                push;
  bundle_t             bundle;
  logic [7:0]          out_byte;
  logic                out_valid;
  logic                done;
  err_e                err;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_BYTES) ? {{(32 - CfgWidth){1'b0}}, max_bytes_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBytesReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_BYTES) begin
      max_bytes_q <= pwdata[CfgWidth-1:0];
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  jsd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .first_i     (s_axis_tuser[0]),
    .final_req_i (s_axis_tlast),
    .max_bytes_i (max_bytes_q),
    .push_o      (push),
    .bundle_o    (bundle)
  );

  jsd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .bundle_i    (bundle),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .take_i      (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_valid_o (out_valid),
    .done_o      (done),
    .err_o       (err),
    .last_o      (m_axis_tlast)
  );

  // Pack the result item
  assign m_axis_tdata = {3'd0, err, done, out_byte};
  assign m_axis_tuser = out_valid;

endmodule

// ----- test/json_string_decoder_tb.sv -----
// Testbench for json_string_decoder: a directed table, then random JSON strings.
// Depends on jsd_pkg and json_string_decoder. Results are checked against a local decoder.
`timescale 1ns / 100ps

module json_string_decoder_tb;
  import jsd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 50;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [19:0] LIMIT_STEPS [5] = '{20'd0, 20'd6, 20'hfffff, 20'd40, MaxBytesReset};

  // One input item and one decoded result
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       fin;
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    err_e       err;
    logic       last;
  } dec_out_t;

  // Directed row; typed rows carry their result here (none, or one status result)
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       fin;
    logic       typed;
    logic       one_res;
    logic       done;
    err_e       err;
  } dir_row_t;

  localparam dir_row_t DIRECTED [32] = '{
    '{8'h00,     1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE},  // ignored before any string
    '{CH_QUOTE,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE},
    '{8'h7f,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{CH_N,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"d",       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"8",       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"3",       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"D",       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"D",       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"E",       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"0",       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"0",       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},  // surrogate pair, four bytes
    '{8'hf4,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'h8f,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'hbf,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{8'hbf,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},  // raw U+10FFFF
    '{CH_QUOTE,  1'b0, 1'b0, 1'b1, 1'b1, 1'b1, ERR_NONE},
    '{8'hff,     1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE},  // ignored after done
    '{8'hff,     1'b1, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE},  // any value opens
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"g",       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{"0",       1'b0, 1'b1, 1'b1, 1'b1, 1'b0, ERR_TRUNC_HEX},
    '{CH_QUOTE,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE},
    '{8'hc3,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE},
    '{CH_QUOTE,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, ERR_NONE},  // drop the open sequence
    '{8'h1f,     1'b0, 1'b0, 1'b1, 1'b1, 1'b0, ERR_BAD_UTF8}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic [0:0]  s_axis_tuser = '0;   // [0] first
  logic        s_axis_tlast = 1'b0; // final_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] out_byte, [8] done_res, [12:9] error_code
  logic [0:0]  m_axis_tuser;        // [0] out_valid
  logic        m_axis_tlast;        // last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Local decoder state
  phase_e      ph = PH_IDLE;
  logic [20:0] acc = '0;
  logic [9:0]  hi_half = '0;
  logic [23:0] held = '0;
  logic [1:0]  remain = '0;
  logic [2:0]  seq_len = '0;
  logic [20:0] dec_count = '0;
  logic [19:0] max_bytes = MaxBytesReset;

  dec_out_t   step_results[$];
  dec_out_t   expected_utf8[$];
  text_item_t text_q[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         taken_items = 0;
  int         rx_tick = 0;
  int         rx_mode = 0;
  int         rx_run = 0;
  bit         rx_level = 1'b0;

  json_string_decoder uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // UTF-8 bytes of a non-surrogate code point, first byte in enc[0]
  function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] enc);
    enc = '0;
    if (cp <= 21'h7f) begin
      enc[0] = cp[7:0];
      return 1;
    end
    if (cp <= 21'h7ff) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp <= 21'hffff) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      return 3;
    end
    enc[0] = {5'b11110, cp[20:18]};
    enc[1] = {2'b10, cp[17:12]};
    enc[2] = {2'b10, cp[11:6]};
    enc[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  // Advance the local decoder by one item; results land in step_results
  task automatic unescape_step(input logic [7:0] b, input logic first, input logic fin,
                               output bit taken);
    logic [3:0][7:0] obuf;
    logic [20:0]     cp;
    logic [21:0]     next;
    int              nb;
    int              h;
    int              count;
    int              i;
    bit              done;
    bit              second;
    bit              bad;
    err_e            err;
    dec_out_t        r;
    step_results.delete();
    obuf = '0;
    nb = 0;
    done = 1'b0;
    err = ERR_NONE;
    taken = 1'b1;
    if (first) begin
      ph = PH_STR;
      acc = '0;
      hi_half = '0;
      remain = '0;
      seq_len = '0;
      dec_count = '0;
    end else begin
      case (ph)
        PH_STR: begin
          if (b == CH_QUOTE) done = 1'b1;
          else if (b == CH_BSLASH) ph = PH_ESC;
          else if (b < 8'h20) err = ERR_BAD_UTF8;
          else if (b <= 8'h7f) begin
            obuf[nb] = b;
            nb++;
          end else if (b >= 8'hc2 && b <= 8'hdf) begin
            acc = 21'(b[4:0]);
            seq_len = 3'd2;
          end else if (b >= 8'he0 && b <= 8'hef) begin
            acc = 21'(b[3:0]);
            seq_len = 3'd3;
          end else if (b >= 8'hf0 && b <= 8'hf4) begin
            acc = 21'(b[2:0]);
            seq_len = 3'd4;
          end else err = ERR_BAD_UTF8;
          // Hold a valid lead byte until its sequence completes
          if (ph == PH_STR && !done && err == ERR_NONE && b >= 8'h80) begin
            held = 24'(b);
            remain = 2'(seq_len - 3'd1);
            ph = PH_UTF8;
          end
        end
        PH_ESC: begin
          ph = PH_STR;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin obuf[nb] = b; nb++; end
            CH_B: begin obuf[nb] = 8'h08; nb++; end
            CH_F: begin obuf[nb] = 8'h0c; nb++; end
            CH_N: begin obuf[nb] = 8'h0a; nb++; end
            CH_R: begin obuf[nb] = 8'h0d; nb++; end
            CH_T: begin obuf[nb] = 8'h09; nb++; end
            CH_U: begin
              ph = PH_HEX1;
              acc = '0;
              remain = '0;
            end
            default: err = ERR_BAD_ESC;
          endcase
        end
        PH_HEX1, PH_HEX1_BAD, PH_HEX2, PH_HEX2_BAD: begin
          h = hex_value(b);
          second = (ph == PH_HEX2 || ph == PH_HEX2_BAD);
          bad = (ph == PH_HEX1_BAD || ph == PH_HEX2_BAD || h < 0);
          if (h >= 0) acc = {5'd0, acc[11:0], 4'(h)};
          // A bad digit is remembered; the escape still takes four digits
          if (remain < 2'd3) begin
            remain = remain + 2'd1;
            if (second) ph = bad ? PH_HEX2_BAD : PH_HEX2;
            else ph = bad ? PH_HEX1_BAD : PH_HEX1;
          end else if (bad) begin
            err = ERR_BAD_HEX;
          end else if (!second) begin
            if (acc >= 21'hd800 && acc <= 21'hdbff) begin
              hi_half = acc[9:0];
              ph = PH_WANT_BS;
            end else if (acc >= 21'hdc00 && acc <= 21'hdfff) begin
              err = ERR_LONE_LOW;
            end else begin
              nb = utf8_encode(acc, obuf);
              ph = PH_STR;
            end
          end else if (acc < 21'hdc00 || acc > 21'hdfff) begin
            err = ERR_BAD_LOW;
          end else begin
            cp = 21'h10000 + 21'({hi_half, acc[9:0]});
            nb = utf8_encode(cp, obuf);
            ph = PH_STR;
          end
        end
        PH_WANT_BS: begin
          if (b == CH_BSLASH) ph = PH_WANT_U;
          else err = ERR_NO_LOW;
        end
        PH_WANT_U: begin
          if (b == CH_U) begin
            ph = PH_HEX2;
            acc = '0;
            remain = '0;
          end else err = ERR_NO_LOW;
        end
        PH_UTF8: begin
          if (b[7:6] != 2'b10) begin
            err = ERR_BAD_UTF8;
          end else begin
            acc = {acc[14:0], b[5:0]};
            if (remain > 2'd1) begin
              remain = remain - 2'd1;
              held = {held[15:0], b};
            end else begin
              cp = acc;
              // Reject overlong forms, surrogates and values past U+10FFFF
              if ((seq_len == 3'd3 && cp < 21'h800) || (seq_len == 3'd4 && cp < 21'h10000) ||
                  (cp >= 21'hd800 && cp <= 21'hdfff) || cp > 21'h10ffff ||
                  seq_len < 3'd2 || seq_len > 3'd4) begin
                err = ERR_BAD_UTF8;
              end else begin
                for (i = 0; i + 1 < int'(seq_len); i++) begin
                  obuf[nb] = held[8 * (int'(seq_len) - 2 - i) +: 8];
                  nb++;
                end
                obuf[nb] = b;
                nb++;
                remain = '0;
                ph = PH_STR;
              end
            end
          end
        end
        default: begin
          taken = 1'b0;
          return;
        end
      endcase
    end

    // Length limit: drop all bytes of an element that would overrun it
    if (err == ERR_NONE && nb > 0) begin
      next = {1'b0, dec_count} + 22'(nb);
      if (next > 22'(max_bytes) || next > 22'h1fffff) begin
        err = ERR_TOO_LONG;
        nb = 0;
      end else dec_count = next[20:0];
    end
    if (err == ERR_NONE && !done && fin) begin
      case (ph)
        PH_ESC: err = ERR_TRUNC_ESC;
        PH_HEX1, PH_HEX1_BAD, PH_HEX2, PH_HEX2_BAD: err = ERR_TRUNC_HEX;
        PH_WANT_BS, PH_WANT_U: err = ERR_NO_LOW;
        PH_UTF8: err = ERR_BAD_UTF8;
        default: err = ERR_UNTERMINATED;
      endcase
    end
    if (err != ERR_NONE || done) ph = PH_IDLE;

    count = nb;
    if (count == 0 && (err != ERR_NONE || done)) count = 1;
    for (i = 0; i < count; i++) begin
      r.data = (i < nb) ? obuf[i] : 8'h00;
      r.valid = (i < nb);
      r.done = (i == count - 1) && done;
      r.err = (i == count - 1) ? err : ERR_NONE;
      r.last = (i == count - 1);
      step_results.insert(step_results.size(), r);
    end
  endtask

  // Drive one item in the current burst, wait for its handshake, then predict
  task automatic send_item(input text_item_t it, output bit taken);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it.data;
    s_axis_tuser <= it.first;
    s_axis_tlast <= it.fin;
    do @(posedge clk_i); while (!s_axis_tready);
    unescape_step(it.data, it.first, it.fin, taken);
  endtask

  // Hold input until every expected result is out and the pipeline is empty
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_utf8.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the length limit, read it back, then mirror it locally
  task automatic set_limit(logic [19:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MAX_BYTES, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) report_mismatch("max_decoded_bytes readback", prdata[15:0],
                                               value[15:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    max_bytes = value;
  endtask

  function automatic void put(logic [7:0] b);
    text_item_t t;
    t = '{data: b, first: 1'b0, fin: 1'b0};
    text_q.insert(text_q.size(), t);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  function automatic void put_u_escape(logic [15:0] v);
    put(CH_BSLASH);
    put(CH_U);
    for (int i = 3; i >= 0; i--) put(hex_char(v[4 * i +: 4]));
  endfunction

  // Build one string: mostly well-formed elements, some broken ones
  function automatic void gen_string();
    logic [3:0][7:0] enc;
    logic [20:0]     cp;
    logic [7:0]      c;
    int              n;
    int              pick;
    int              pos;
    text_item_t      opener;
    c = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CH_QUOTE;
    opener = '{data: c, first: 1'b1, fin: 1'b0};
    text_q.insert(text_q.size(), opener);
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        do c = 8'($urandom_range(8'h20, 8'h7f)); while (c == CH_QUOTE || c == CH_BSLASH);
        put(c);
      end else if (pick < 50) begin
        put(CH_BSLASH);
        case ($urandom_range(0, 7))
          0: put(CH_QUOTE);
          1: put(CH_BSLASH);
          2: put(CH_SLASH);
          3: put(CH_B);
          4: put(CH_F);
          5: put(CH_N);
          6: put(CH_R);
          default: put(CH_T);
        endcase
      end else if (pick < 60) begin
        case ($urandom_range(0, 2))
          0: cp = 21'($urandom_range(0, 16'h7f));
          1: cp = 21'($urandom_range(0, 16'h7ff));
          default: do cp = 21'($urandom_range(0, 16'hffff));
                   while (cp >= 21'hd800 && cp <= 21'hdfff);
        endcase
        put_u_escape(cp[15:0]);
      end else if (pick < 67) begin
        put_u_escape(16'hd800 + 16'($urandom_range(0, 1023)));
        put_u_escape(16'hdc00 + 16'($urandom_range(0, 1023)));
      end else if (pick < 82) begin
        case ($urandom_range(0, 2))
          0: cp = 21'($urandom_range(21'h80, 21'h7ff));
          1: do cp = 21'($urandom_range(21'h800, 21'hffff));
             while (cp >= 21'hd800 && cp <= 21'hdfff);
          default: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
        endcase
        n = utf8_encode(cp, enc);
        for (int i = 0; i < n; i++) put(enc[i]);
      end else begin
        case ($urandom_range(0, 8))
          0: put(8'($urandom));
          1: begin
            put(CH_BSLASH);
            put(8'($urandom));
          end
          2: begin
            put(CH_BSLASH);
            put(CH_U);
            pos = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++) put((i == pos) ? 8'($urandom) : hex_char(4'($urandom)));
          end
          3: put_u_escape(16'hdc00 + 16'($urandom_range(0, 1023)));
          4: begin
            put_u_escape(16'hd800 + 16'($urandom_range(0, 1023)));
            if ($urandom_range(0, 1)) put(CH_BSLASH);
            put(8'($urandom));
          end
          5: begin
            put_u_escape(16'hd800 + 16'($urandom_range(0, 1023)));
            put_u_escape(16'($urandom));
          end
          6: begin
            put(8'($urandom_range(8'h80, 8'hff)));
            repeat ($urandom_range(0, 3)) put(8'($urandom_range(8'h80, 8'hbf)));
          end
          7: begin
            // overlong, surrogate, above U+10FFFF
            case ($urandom_range(0, 4))
              0: begin put(8'he0); put(8'($urandom_range(8'h80, 8'h9f))); end
              1: begin put(8'hed); put(8'($urandom_range(8'ha0, 8'hbf))); end
              2: begin put(8'hf0); put(8'($urandom_range(8'h80, 8'h8f))); put(8'h80); end
              3: begin put(8'hf4); put(8'($urandom_range(8'h90, 8'hbf))); put(8'h80); end
              default: put(8'($urandom_range(8'hc0, 8'hc1)));
            endcase
            put(8'($urandom_range(8'h80, 8'hbf)));
          end
          default: put(8'($urandom_range(0, 8'h1f)));
        endcase
      end
    end
    if ($urandom_range(0, 99) < 85) put(CH_QUOTE);
    // Cut the text short at a random item
    if ($urandom_range(0, 9) == 0) text_q[$urandom_range(0, text_q.size() - 1)].fin = 1'b1;
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) put(8'($urandom));
  endfunction

  // Receiver: the ready pattern switches among four random modes
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_tick % 100 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_tick % 4 == 0);
      default: begin
        if (rx_run == 0) begin
          rx_run = $urandom_range(1, 10);
          rx_level = ~rx_level;
        end
        rx_run--;
        m_axis_tready <= rx_level;
      end
    endcase
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    dec_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_utf8.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 16'h0);
      end else begin
        want = expected_utf8.pop_front();
        if (m_axis_tdata[7:0] !== want.data)
          report_mismatch("out_byte", m_axis_tdata[7:0], want.data);
        if (m_axis_tuser[0] !== want.valid)
          report_mismatch("out_valid", m_axis_tuser[0], want.valid);
        if (m_axis_tdata[8] !== want.done)
          report_mismatch("done_res", m_axis_tdata[8], want.done);
        if (m_axis_tdata[12:9] !== want.err)
          report_mismatch("error_code", m_axis_tdata[12:9], want.err);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    bit       taken;
    dec_out_t status_res;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < 32; r++) begin
      send_item('{data: DIRECTED[r].data, first: DIRECTED[r].first, fin: DIRECTED[r].fin},
                taken);
      if (DIRECTED[r].typed) begin
        if (DIRECTED[r].one_res) begin
          status_res = '{data: 8'h00, valid: 1'b0, done: DIRECTED[r].done,
                         err: DIRECTED[r].err, last: 1'b1};
          expected_utf8.insert(expected_utf8.size(), status_res);
        end
      end else begin
        foreach (step_results[k]) expected_utf8.insert(expected_utf8.size(), step_results[k]);
      end
    end
    drain_results();

    // Random strings under each length limit
    foreach (LIMIT_STEPS[p]) begin
      set_limit(LIMIT_STEPS[p]);
      taken_items = 0;
      while (taken_items < PHASE_ITEMS) begin
        gen_string();
        while (text_q.size() != 0) begin
          send_item(text_q.pop_front(), taken);
          foreach (step_results[k]) expected_utf8.insert(expected_utf8.size(), step_results[k]);
          if (taken) taken_items++;
        end
        if ($urandom_range(0, 7) == 0) drain_results();
      end
      drain_results();
    end

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/jsd_pkg.sv
src/jsd_decode.sv
src/jsd_outq.sv
src/json_string_decoder.sv
test/json_string_decoder_tb.sv
